@@ hw/rtl/smdup_pkg.sv @@
// Package for the sort-and-merge block: sizes, item types, state codes.
// No dependencies.
`default_nettype none
package smdup_pkg;

    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [15:0] TOL_RESET = 16'd66;
    localparam logic [1:0]  ADDR_TOL  = 2'd0;

    typedef struct packed {
        logic signed [31:0] position_key;
        logic signed [31:0] sample_value;
        logic               valid_mark;
        logic               last_entry;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_position;
        logic signed [31:0] out_value;
        logic               out_mark;
        logic               out_last;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic               mark;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INS   = 5'b00010,
        S_PLACE = 5'b00100,
        S_SWEEP = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/smdup_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module smdup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/smdup_cfg.sv @@
// APB register file holding the merge tolerance.
// Depends on smdup_pkg.
`default_nettype none
module smdup_cfg
    import smdup_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [15:0] tol
);

    logic [15:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_TOL))
        begin
            tol_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {16'd0, tol_reg};
    assign tol    = tol_reg;

endmodule
`default_nettype wire

@@ hw/rtl/sort_and_merge_near_duplicates_core.sv @@
// Top level: insertion sort into RAM, then merge sweep of near-equal keys.
// Depends on smdup_pkg, smdup_ram, smdup_cfg.
// Insert: larger keys shift up until the new key fits; an empty store is written directly.
// Sweep: one entry read per cycle from the RAM port.
// Throughput set by the single RAM read port; results cannot be stalled.
// Reset clears the entry count and control state; RAM contents are not cleared.
`default_nettype none
module sort_and_merge_near_duplicates_core
    import smdup_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    output out_item_t        out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [15:0] tol;

    smdup_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tol     (tol)
    );

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   pos_reg, pos_next;
    entry_t          new_reg, new_next;
    logic            last_reg, last_next;
    logic [CW-1:0]   rd_reg, rd_next;
    logic            dv_reg, dv_next;
    logic            have_reg, have_next;
    entry_t          cur_reg, cur_next;
    logic signed [31:0] prev_reg, prev_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_item_reg, out_item_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    entry_t          wdata, rentry;
    logic [EW-1:0]   rword;
    logic signed [32:0] diff;
    logic            accept;

    smdup_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rword)
    );

    assign rentry = entry_t'(rword);
    assign accept = start && (state_reg == S_IDLE);
    assign diff   = {rentry.key[31], rentry.key} - {prev_reg[31], prev_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        new_next       = new_reg;
        last_next      = last_reg;
        rd_next        = rd_reg;
        dv_next        = 1'b0;
        have_next      = have_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        out_valid_next = 1'b0;
        out_item_next  = out_item_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = new_reg;
        raddr          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    new_next  = '{key: in_item.position_key, value: in_item.sample_value,
                                  mark: in_item.valid_mark};
                    last_next = in_item.last_entry;
                    rd_next   = '0;
                    have_next = 1'b0;
                    if (count_reg == CW'(DEPTH))
                    begin
                        if (in_item.last_entry)
                        begin
                            state_next = S_SWEEP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = new_next;
                        count_next = count_reg + 1'b1;
                        if (in_item.last_entry)
                        begin
                            state_next = S_SWEEP;
                        end
                    end
                    else
                    begin
                        pos_next   = count_reg[AW-1:0];
                        raddr      = AW'(count_reg - 1'b1);
                        state_next = S_INS;
                    end
                end
            end
            S_INS:
            begin
                we = 1'b1;
                if (rentry.key > new_reg.key)
                begin
                    wdata    = rentry;
                    pos_next = pos_reg - 1'b1;
                    if (pos_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? S_SWEEP : S_IDLE;
                end
            end
            S_PLACE:
            begin
                we         = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = last_reg ? S_SWEEP : S_IDLE;
            end
            S_SWEEP:
            begin
                if (rd_reg != count_reg)
                begin
                    raddr   = rd_reg[AW-1:0];
                    rd_next = rd_reg + 1'b1;
                    dv_next = 1'b1;
                end
                if (dv_reg)
                begin
                    prev_next = rentry.key;
                    if (have_reg && (diff <= $signed({17'd0, tol})))
                    begin
                        if (rentry.value > cur_reg.value)
                        begin
                            cur_next.value = rentry.value;
                        end
                    end
                    else
                    begin
                        if (have_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = '{out_position: cur_reg.key,
                                               out_value: cur_reg.value,
                                               out_mark: cur_reg.mark, out_last: 1'b0};
                        end
                        cur_next  = rentry;
                        have_next = 1'b1;
                    end
                    if (rd_reg == count_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                out_valid_next = 1'b1;
                out_item_next  = '{out_position: cur_reg.key, out_value: cur_reg.value,
                                   out_mark: cur_reg.mark, out_last: 1'b1};
                count_next     = '0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            dv_reg        <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            dv_reg        <= dv_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        new_reg      <= new_next;
        last_reg     <= last_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        out_item_reg <= out_item_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

@@ hw/rtl/smdup_checker.sv @@
// Port-level checks for the sort-and-merge core, bound to the top level.
// Depends on smdup_pkg.
`default_nettype none
module smdup_checker
    import smdup_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        out_valid,
    input wire out_item_t   out_item,
    input wire logic        pready,
    input wire logic [31:0] prdata
);

    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.out_last |-> busy) else $error("item out while idle");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_last |=> !out_valid) else $error("item after last");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_last |-> !busy) else $error("busy with last");

    a_prdata: assert property (@(posedge clk) disable iff (!rst_n)
        pready |-> prdata[31:16] == 16'd0) else $error("prdata upper bits set");

endmodule

bind sort_and_merge_near_duplicates_core smdup_checker u_smdup_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .pready    (pready),
    .prdata    (prdata)
);
`default_nettype wire
